/* hw/rtl/spm_pkg.sv */
// Shared types and constants for the strict-priority multi-FIFO block.
// No dependencies; imported by spm_qstore and strict_priority_multi_fifo_top.
`timescale 1ns / 1ps

package spm_pkg;

    // Fixed field widths of the stream payloads
    localparam int ID_W      = 16;
    localparam int CLS_W     = 3;
    localparam int REQ_W     = 2;
    localparam int S_TDATA_W = 24;   // priority_class + item_id, padded to bytes
    localparam int M_TDATA_W = 56;   // all result fields, padded to bytes

    // Default configuration
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_NUM_CLASSES = 6;

    // Command codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_SERVE   = 2'd1,
        REQ_WAIT    = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    // Control sequencer states
    typedef enum logic {
        SPM_IDLE = 1'b0,
        SPM_READ = 1'b1
    } spm_state_t;

endpackage

/* hw/rtl/spm_qstore.sv */
// Queue storage: one synchronous memory holding every class FIFO back to back.
// One write port, two registered read ports with write-first forwarding.
// Depends on spm_pkg.
`timescale 1ns / 1ps

module spm_qstore #(
    parameter int NUM_CLASSES = spm_pkg::DEF_NUM_CLASSES,
    parameter int QUEUE_DEPTH = spm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [$clog2(NUM_CLASSES*QUEUE_DEPTH)-1:0]   wr_addr,
    input  logic [spm_pkg::ID_W-1:0]                     wr_data,
    input  logic                                         rd_en,
    input  logic [$clog2(NUM_CLASSES*QUEUE_DEPTH)-1:0]   rd_addr_a,
    input  logic [$clog2(NUM_CLASSES*QUEUE_DEPTH)-1:0]   rd_addr_b,
    output logic [spm_pkg::ID_W-1:0]                     rd_data_a,
    output logic [spm_pkg::ID_W-1:0]                     rd_data_b
);
    import spm_pkg::*;

    localparam int ENTRIES = NUM_CLASSES * QUEUE_DEPTH;

    logic [ID_W-1:0] mem [ENTRIES];
    logic [ID_W-1:0] rd_data_a_reg;
    logic [ID_W-1:0] rd_data_b_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read ports: forward a write to the same entry in the same cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
            rd_data_b_reg <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

/* hw/rtl/strict_priority_multi_fifo_top.sv */
// Top level of the strict-priority multi-FIFO block: control, pointers, result register.
// Depends on spm_pkg and spm_qstore.
`timescale 1ns / 1ps
//
// Usage:
//   Slave channel s_axis_*: one command transaction per item. tuser carries the
//   command (enqueue, serve, wait, clear); tdata carries the class and item id.
//   Master channel m_axis_* result: one transaction per command with the served
//   item, the drop flag and the heads of the prioritised and normal classes.
//   An accepted command moves the sequencer to the read state; the result is registered
//   there once the result register is free. No new command is taken until then. The
//   peek of the new queue heads is a read of the queue memory after the pointer
//   update, and that memory has registered read ports.
//   Each class FIFO holds QUEUE_DEPTH ids; an enqueue into a full class is
//   discarded and flagged, an enqueue to a class beyond NUM_CLASSES-1 is ignored.
//   Reset empties all queues (pointers and counts only; the memory is not
//   swept) and the block is ready for a command as soon as reset is released.
//   When the receiver stalls, the result register holds; one more command is
//   taken and then the block waits until the held result is taken.

module strict_priority_multi_fifo_top #(
    parameter int QUEUE_DEPTH = spm_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_CLASSES = spm_pkg::DEF_NUM_CLASSES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [spm_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [2:0] priority_class, [18:3] item_id
    input  logic [spm_pkg::REQ_W-1:0]     s_axis_tuser,  // [1:0] req_type
    // result channel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] served_valid, [16:1] served_id, [19:17] served_class, [20] enqueue_dropped,
    // [21] next_prio_valid, [37:22] next_prio_id, [38] next_normal_valid,
    // [54:39] next_normal_id
    output logic [spm_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import spm_pkg::*;

    localparam int PW     = $clog2(QUEUE_DEPTH);
    localparam int CNTW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CIW    = $clog2(NUM_CLASSES);
    localparam int AW     = $clog2(NUM_CLASSES * QUEUE_DEPTH);
    localparam int NORMAL = NUM_CLASSES - 1;

    // Sequencer and queue state
    spm_state_t      state_reg, state_next;
    logic [PW-1:0]   head_reg [NUM_CLASSES];
    logic [PW-1:0]   tail_reg [NUM_CLASSES];
    logic [CNTW-1:0] cnt_reg  [NUM_CLASSES];
    logic [PW-1:0]   head_next [NUM_CLASSES];
    logic [PW-1:0]   tail_next [NUM_CLASSES];
    logic [CNTW-1:0] cnt_next  [NUM_CLASSES];

    // Current heads, as of the last finished command
    logic [ID_W-1:0] p_peek_reg;
    logic [ID_W-1:0] n_peek_reg;

    // Per-command values carried from accept to result
    logic            srv_valid_reg, srv_valid_next;
    logic [CLS_W-1:0] srv_cls_reg, srv_cls_next;
    logic [ID_W-1:0] srv_id_reg, srv_id_next;
    logic            drop_reg, drop_next;
    logic            pv_reg, pv_next;
    logic            nv_reg, nv_next;

    // Result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Command fields
    req_t             req;
    logic [CLS_W-1:0] cls;
    logic [ID_W-1:0]  id;
    logic             accept;
    logic             load_out;

    // Memory interface
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr_a;
    logic [AW-1:0]   rd_addr_b;
    logic [ID_W-1:0] rd_data_a;
    logic [ID_W-1:0] rd_data_b;

    logic            srv_hit;
    logic [CIW-1:0]  srv_sel;
    logic            enq_ok;

    assign req    = req_t'(s_axis_tuser);
    assign cls    = s_axis_tdata[CLS_W-1:0];
    assign id     = s_axis_tdata[CLS_W+ID_W-1:CLS_W];
    assign s_axis_tready = (state_reg == SPM_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign load_out = (state_reg == SPM_READ) && (!m_tvalid_reg || m_axis_tready);
    assign enq_ok = ({1'b0, cls} < (CLS_W+1)'(NUM_CLASSES));

    // Pick the class to serve from the state before the command
    always_comb
    begin
        srv_hit = 1'b0;
        srv_sel = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (cnt_reg[i] != '0)
            begin
                srv_hit = 1'b1;
                srv_sel = CIW'(i);
            end
        end
    end

    // Update pointers and counts, issue the write and the head reads
    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = '0;
        drop_next      = 1'b0;
        srv_valid_next = 1'b0;
        srv_cls_next   = '0;
        srv_id_next    = '0;
        pv_next        = 1'b0;
        nv_next        = 1'b0;
        rd_addr_a      = '0;
        rd_addr_b      = '0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            cnt_next[i]  = cnt_reg[i];
        end

        case (req)
            REQ_ENQUEUE:
            begin
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    if (enq_ok && (cls == CLS_W'(i)))
                    begin
                        if (cnt_reg[i] == CNTW'(QUEUE_DEPTH))
                        begin
                            drop_next = 1'b1;
                        end
                        else
                        begin
                            wr_en        = accept;
                            wr_addr      = AW'(i * QUEUE_DEPTH) + AW'(tail_reg[i]);
                            tail_next[i] = (tail_reg[i] == PW'(QUEUE_DEPTH - 1)) ?
                                           '0 : tail_reg[i] + 1'b1;
                            cnt_next[i]  = cnt_reg[i] + 1'b1;
                        end
                    end
                end
            end
            REQ_SERVE:
            begin
                srv_valid_next = srv_hit;
                if (srv_hit)
                begin
                    srv_cls_next = CLS_W'(srv_sel);
                    srv_id_next  = (srv_sel == CIW'(NORMAL)) ? n_peek_reg : p_peek_reg;
                end
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    if (srv_hit && (srv_sel == CIW'(i)))
                    begin
                        head_next[i] = (head_reg[i] == PW'(QUEUE_DEPTH - 1)) ?
                                       '0 : head_reg[i] + 1'b1;
                        cnt_next[i]  = cnt_reg[i] - 1'b1;
                    end
                end
            end
            REQ_WAIT:
            begin
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    head_next[i] = '0;
                    tail_next[i] = '0;
                    cnt_next[i]  = '0;
                end
            end
            default:
            begin
            end
        endcase

        // Heads after the command: highest non-empty prioritised class, and normal
        for (int i = NORMAL - 1; i >= 0; i--)
        begin
            if (cnt_next[i] != '0)
            begin
                pv_next   = 1'b1;
                rd_addr_a = AW'(i * QUEUE_DEPTH) + AW'(head_next[i]);
            end
        end
        nv_next   = (cnt_next[NORMAL] != '0);
        rd_addr_b = AW'(NORMAL * QUEUE_DEPTH) + AW'(head_next[NORMAL]);
    end

    spm_qstore #(
        .NUM_CLASSES (NUM_CLASSES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_qstore (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (id),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SPM_IDLE:
            begin
                if (accept)
                begin
                    state_next = SPM_READ;
                end
            end
            SPM_READ:
            begin
                if (load_out)
                begin
                    state_next = SPM_IDLE;
                end
            end
            default:
            begin
                state_next = SPM_IDLE;
            end
        endcase
    end

    // Control state: sequencer, pointers, counts, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SPM_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    head_reg[i] <= head_next[i];
                    tail_reg[i] <= tail_next[i];
                    cnt_reg[i]  <= cnt_next[i];
                end
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Hold per-command values from accept until the result is built
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            srv_valid_reg <= srv_valid_next;
            srv_cls_reg   <= srv_cls_next;
            srv_id_reg    <= srv_id_next;
            drop_reg      <= drop_next;
            pv_reg        <= pv_next;
            nv_reg        <= nv_next;
        end
    end

    // Build the result and refresh the head copies
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            p_peek_reg  <= rd_data_a;
            n_peek_reg  <= rd_data_b;
            m_tdata_reg <= {1'b0,
                            nv_reg ? rd_data_b : {ID_W{1'b0}},
                            nv_reg,
                            pv_reg ? rd_data_a : {ID_W{1'b0}},
                            pv_reg,
                            drop_reg,
                            srv_cls_reg,
                            srv_id_reg,
                            srv_valid_reg};
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // Checks
    a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == SPM_READ))
        else $error("accepted command did not start the head read");

    a_read_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (m_tvalid_reg && (state_reg == SPM_IDLE)))
        else $error("head read did not produce a result");

    for (genvar g = 0; g < NUM_CLASSES; g++)
    begin : g_chk
        a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
            cnt_reg[g] <= CNTW'(QUEUE_DEPTH))
            else $error("class occupancy above queue depth");

        a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
            (cnt_reg[g] == '0) |-> (head_reg[g] == tail_reg[g]))
            else $error("empty class with head and tail apart");
    end

endmodule
